// File: hdl/soc_pkg.sv
// Shared constants for the slice order comparator.
// Fixed field widths of the request and the flag bit positions.
// No dependencies.
`default_nettype none

package soc_pkg;

  // Request field widths fixed by the record layout
  localparam int POS_FIELD_WIDTH = 63;
  localparam int ORI_FIELD_WIDTH = 60;
  localparam int FLAG_WIDTH      = 2;
  localparam int INST_WIDTH      = 24;
  localparam int LOC_WIDTH       = 21;
  localparam int IDX_WIDTH       = 16;

  // Tolerance register
  localparam int TOL_WIDTH       = 20;

  // Flag bits
  localparam int FLAG_POS        = 0;
  localparam int FLAG_ORI        = 1;

endpackage : soc_pkg

`default_nettype wire

// File: hdl/slice_order_comparator.sv
// Slice order comparator top level: six-stage pipelined ordering decision.
// Depends on soc_pkg (field widths, flag bit positions).
`default_nettype none

// Decides whether the left slice sorts strictly before the right one. The
// block is a six-stage pipeline: it takes one request per cycle while the
// output is not stalled and holds each answer while the output stalls. Stages:
// field decode and cross-product terms; slice normal and projection terms;
// projection sum and |n|^2; split partial products of the squared projection
// and of tol^2*|n|^2; partial-product sums; final compare into the output
// register. Each stage holds its request when the next one is full and
// stalled, so empty stages still fill while the output waits. The tolerance
// register is written through cfg_wr_en / cfg_wr_data and resets to zero.
module slice_order_comparator #(
  parameter int POSITION_WIDTH = 21,
  parameter int COSINE_WIDTH   = 10
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_wr_en,
  input  logic [soc_pkg::TOL_WIDTH-1:0]         cfg_wr_data,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [soc_pkg::POS_FIELD_WIDTH-1:0]   in_left_position,
  input  logic [soc_pkg::ORI_FIELD_WIDTH-1:0]   in_left_orientation,
  input  logic [soc_pkg::FLAG_WIDTH-1:0]        in_left_flags,
  input  logic signed [soc_pkg::INST_WIDTH-1:0] in_left_instance,
  input  logic signed [soc_pkg::LOC_WIDTH-1:0]  in_left_slice_location,
  input  logic [soc_pkg::IDX_WIDTH-1:0]         in_left_order_index,
  input  logic [soc_pkg::POS_FIELD_WIDTH-1:0]   in_right_position,
  input  logic [soc_pkg::ORI_FIELD_WIDTH-1:0]   in_right_orientation,
  input  logic [soc_pkg::FLAG_WIDTH-1:0]        in_right_flags,
  input  logic signed [soc_pkg::INST_WIDTH-1:0] in_right_instance,
  input  logic signed [soc_pkg::LOC_WIDTH-1:0]  in_right_slice_location,
  input  logic [soc_pkg::IDX_WIDTH-1:0]         in_right_order_index,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_left_before_right
);

  localparam int W      = POSITION_WIDTH;
  localparam int C      = COSINE_WIDTH;
  localparam int DW     = W + 1;                 // position difference
  localparam int XW     = 2 * C;                 // cosine product
  localparam int NW     = 2 * C + 1;             // normal component
  localparam int PW     = DW + NW;               // projection d.n
  localparam int APW    = PW - 1;                // |d.n|
  localparam int AL     = (APW + 1) / 2;
  localparam int AH     = APW - AL;
  localparam int QW     = 2 * NW;                // |n|^2
  localparam int QL     = (QW + 1) / 2;
  localparam int QH     = QW - QL;
  localparam int TOLW   = soc_pkg::TOL_WIDTH;
  localparam int TW     = 2 * TOLW;              // tol^2
  localparam int TL     = TW / 2;
  localparam int TH     = TW - TL;
  localparam int SQW    = 2 * APW;
  localparam int TQW    = TW + QW;
  localparam int CMPW   = (SQW > TQW) ? SQW : TQW;
  localparam int LDW    = soc_pkg::LOC_WIDTH + 1; // location difference
  localparam int MW     = (DW > TOLW) ? DW : TOLW;
  localparam int LMW    = (LDW > TOLW) ? LDW : TOLW;
  localparam int STAGES = 6;

  // ---------------------------------------------------------------------------
  // Tolerance register
  // ---------------------------------------------------------------------------
  logic [TOLW-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its occupant moves
  // ---------------------------------------------------------------------------
  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] adv;

  always_comb begin
    adv[STAGES-1] = !vld_r[STAGES-1] || !out_stall;
    for (int k = STAGES - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: field decode, position deltas, cross-product terms, key compares
  // ---------------------------------------------------------------------------
  logic signed [W-1:0]   lpos [3];
  logic signed [W-1:0]   rpos [3];
  logic signed [C-1:0]   lrow [3];
  logic signed [C-1:0]   lcol [3];
  logic signed [C-1:0]   rrow [3];
  logic signed [C-1:0]   rcol [3];
  logic signed [DW-1:0]  s1_d_nxt [3];
  logic signed [XW-1:0]  s1_lx_nxt [6];
  logic signed [XW-1:0]  s1_rx_nxt [6];
  logic signed [LDW-1:0] s1_ldiff_nxt;
  logic [TW-1:0]         s1_tol2_nxt;

  logic signed [DW-1:0]  s1_d_r [3];
  logic signed [XW-1:0]  s1_lx_r [6];
  logic signed [XW-1:0]  s1_rx_r [6];
  logic                  s1_lori_r;
  logic                  s1_rori_r;
  logic                  s1_both_r;
  logic                  s1_inst_ne_r;
  logic                  s1_inst_lt_r;
  logic signed [LDW-1:0] s1_ldiff_r;
  logic                  s1_idx_lt_r;
  logic [TW-1:0]         s1_tol2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lpos[i] = in_left_position[i*W +: W];
      rpos[i] = in_right_position[i*W +: W];
      lrow[i] = in_left_orientation[i*C +: C];
      lcol[i] = in_left_orientation[(i+3)*C +: C];
      rrow[i] = in_right_orientation[i*C +: C];
      rcol[i] = in_right_orientation[(i+3)*C +: C];
      s1_d_nxt[i] = DW'(lpos[i]) - DW'(rpos[i]);
    end
    // terms in pairs: n[k] = even term - odd term
    s1_lx_nxt[0] = lrow[1] * lcol[2];
    s1_lx_nxt[1] = lrow[2] * lcol[1];
    s1_lx_nxt[2] = lrow[2] * lcol[0];
    s1_lx_nxt[3] = lrow[0] * lcol[2];
    s1_lx_nxt[4] = lrow[0] * lcol[1];
    s1_lx_nxt[5] = lrow[1] * lcol[0];
    s1_rx_nxt[0] = rrow[1] * rcol[2];
    s1_rx_nxt[1] = rrow[2] * rcol[1];
    s1_rx_nxt[2] = rrow[2] * rcol[0];
    s1_rx_nxt[3] = rrow[0] * rcol[2];
    s1_rx_nxt[4] = rrow[0] * rcol[1];
    s1_rx_nxt[5] = rrow[1] * rcol[0];
    s1_ldiff_nxt = LDW'(in_left_slice_location) - LDW'(in_right_slice_location);
    s1_tol2_nxt  = TW'(tol_r) * TW'(tol_r);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < 3; i++) begin
        s1_d_r[i] <= s1_d_nxt[i];
      end
      for (int i = 0; i < 6; i++) begin
        s1_lx_r[i] <= s1_lx_nxt[i];
        s1_rx_r[i] <= s1_rx_nxt[i];
      end
      s1_lori_r    <= in_left_flags[soc_pkg::FLAG_ORI];
      s1_rori_r    <= in_right_flags[soc_pkg::FLAG_ORI];
      s1_both_r    <= in_left_flags[soc_pkg::FLAG_POS] && in_right_flags[soc_pkg::FLAG_POS];
      s1_inst_ne_r <= in_left_instance != in_right_instance;
      s1_inst_lt_r <= in_left_instance < in_right_instance;
      s1_ldiff_r   <= s1_ldiff_nxt;
      s1_idx_lt_r  <= in_left_order_index < in_right_order_index;
      s1_tol2_r    <= s1_tol2_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: normal select, projection terms, |n|^2 terms, fallback decision
  // ---------------------------------------------------------------------------
  logic signed [NW-1:0]  nl [3];
  logic signed [NW-1:0]  nr [3];
  logic signed [NW-1:0]  nsel [3];
  logic                  nl_nz;
  logic                  nr_nz;
  logic                  has_n;
  logic signed [PW-1:0]  s2_dn_nxt [3];
  logic signed [QW-1:0]  nsq [3];
  logic [DW-1:0]         ad [3];
  logic [LDW-1:0]        ald;
  logic                  s2_fb_nxt;
  logic                  axis_hit;

  logic signed [PW-1:0]  s2_dn_r [3];
  logic [QW-1:0]         s2_nsq_r [3];
  logic                  s2_geo_r;
  logic                  s2_fb_r;
  logic [TW-1:0]         s2_tol2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nl[i] = NW'(s1_lx_r[2*i]) - NW'(s1_lx_r[2*i+1]);
      nr[i] = NW'(s1_rx_r[2*i]) - NW'(s1_rx_r[2*i+1]);
    end
    nl_nz = (nl[0] != '0) || (nl[1] != '0) || (nl[2] != '0);
    nr_nz = (nr[0] != '0) || (nr[1] != '0) || (nr[2] != '0);
    has_n = (s1_lori_r && nl_nz) || (s1_rori_r && nr_nz);
    for (int i = 0; i < 3; i++) begin
      nsel[i]      = (s1_lori_r && nl_nz) ? nl[i] : nr[i];
      s2_dn_nxt[i] = s1_d_r[i] * nsel[i];
      nsq[i]       = nsel[i] * nsel[i];
      ad[i]        = s1_d_r[i][DW-1] ? DW'(-s1_d_r[i]) : DW'(s1_d_r[i]);
    end
    ald = s1_ldiff_r[LDW-1] ? LDW'(-s1_ldiff_r) : LDW'(s1_ldiff_r);

    // fallback chain: axis deltas, instance, location, load order
    s2_fb_nxt = s1_idx_lt_r;
    if (LMW'(ald) > LMW'(tol_r)) begin
      s2_fb_nxt = s1_ldiff_r[LDW-1];
    end
    if (s1_inst_ne_r) begin
      s2_fb_nxt = s1_inst_lt_r;
    end
    axis_hit = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (s1_both_r && !axis_hit && (MW'(ad[i]) > MW'(tol_r))) begin
        s2_fb_nxt = s1_d_r[i][DW-1];
        axis_hit  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        s2_dn_r[i]  <= s2_dn_nxt[i];
        s2_nsq_r[i] <= nsq[i];
      end
      s2_geo_r  <= s1_both_r && has_n;
      s2_fb_r   <= s2_fb_nxt;
      s2_tol2_r <= s1_tol2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: projection sum and magnitude, |n|^2 sum
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] p_sum;
  logic [QW-1:0]        s3_nn_nxt;

  logic [APW-1:0]       s3_ap_r;
  logic                 s3_pneg_r;
  logic [QW-1:0]        s3_nn_r;
  logic                 s3_geo_r;
  logic                 s3_fb_r;
  logic [TW-1:0]        s3_tol2_r;

  always_comb begin
    p_sum     = s2_dn_r[0] + s2_dn_r[1] + s2_dn_r[2];
    s3_nn_nxt = s2_nsq_r[0] + s2_nsq_r[1] + s2_nsq_r[2];
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_ap_r   <= p_sum[PW-1] ? APW'(-p_sum) : APW'(p_sum);
      s3_pneg_r <= p_sum[PW-1];
      s3_nn_r   <= s3_nn_nxt;
      s3_geo_r  <= s2_geo_r;
      s3_fb_r   <= s2_fb_r;
      s3_tol2_r <= s2_tol2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: partial products of |p|^2 and tol^2 * |n|^2
  // ---------------------------------------------------------------------------
  logic [AL-1:0]      a_lo;
  logic [AH-1:0]      a_hi;
  logic [QL-1:0]      q_lo;
  logic [QH-1:0]      q_hi;
  logic [TL-1:0]      t_lo;
  logic [TH-1:0]      t_hi;

  logic [2*AH-1:0]    s4_aa_hh_r;
  logic [AH+AL-1:0]   s4_aa_hl_r;
  logic [2*AL-1:0]    s4_aa_ll_r;
  logic [TH+QH-1:0]   s4_tq_hh_r;
  logic [TH+QL-1:0]   s4_tq_hl_r;
  logic [TL+QH-1:0]   s4_tq_lh_r;
  logic [TL+QL-1:0]   s4_tq_ll_r;
  logic               s4_pneg_r;
  logic               s4_geo_r;
  logic               s4_fb_r;

  always_comb begin
    a_lo = s3_ap_r[AL-1:0];
    a_hi = s3_ap_r[APW-1:AL];
    q_lo = s3_nn_r[QL-1:0];
    q_hi = s3_nn_r[QW-1:QL];
    t_lo = s3_tol2_r[TL-1:0];
    t_hi = s3_tol2_r[TW-1:TL];
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_aa_hh_r <= (2*AH)'(a_hi) * (2*AH)'(a_hi);
      s4_aa_hl_r <= (AH+AL)'(a_hi) * (AH+AL)'(a_lo);
      s4_aa_ll_r <= (2*AL)'(a_lo) * (2*AL)'(a_lo);
      s4_tq_hh_r <= (TH+QH)'(t_hi) * (TH+QH)'(q_hi);
      s4_tq_hl_r <= (TH+QL)'(t_hi) * (TH+QL)'(q_lo);
      s4_tq_lh_r <= (TL+QH)'(t_lo) * (TL+QH)'(q_hi);
      s4_tq_ll_r <= (TL+QL)'(t_lo) * (TL+QL)'(q_lo);
      s4_pneg_r  <= s3_pneg_r;
      s4_geo_r   <= s3_geo_r;
      s4_fb_r    <= s3_fb_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: sum the partial products into full-width squares
  // ---------------------------------------------------------------------------
  logic [CMPW-1:0] s5_sq_nxt;
  logic [CMPW-1:0] s5_tq_nxt;

  logic [CMPW-1:0] s5_sq_r;
  logic [CMPW-1:0] s5_tq_r;
  logic            s5_pneg_r;
  logic            s5_geo_r;
  logic            s5_fb_r;

  always_comb begin
    // cross term counted twice
    s5_sq_nxt = (CMPW'(s4_aa_hh_r) << (2*AL)) + (CMPW'(s4_aa_hl_r) << (AL+1))
              + CMPW'(s4_aa_ll_r);
    s5_tq_nxt = (CMPW'(s4_tq_hh_r) << (TL+QL)) + (CMPW'(s4_tq_hl_r) << TL)
              + (CMPW'(s4_tq_lh_r) << QL) + CMPW'(s4_tq_ll_r);
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_sq_r   <= s5_sq_nxt;
      s5_tq_r   <= s5_tq_nxt;
      s5_pneg_r <= s4_pneg_r;
      s5_geo_r  <= s4_geo_r;
      s5_fb_r   <= s4_fb_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: projection test against tolerance, output register
  // ---------------------------------------------------------------------------
  logic out_lbr_nxt;
  logic out_lbr_r;

  always_comb begin
    if (s5_geo_r && (s5_sq_r > s5_tq_r)) begin
      out_lbr_nxt = s5_pneg_r;
    end else begin
      out_lbr_nxt = s5_fb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      out_lbr_r <= out_lbr_nxt;
    end
  end

  assign out_left_before_right = out_lbr_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a free output means the whole pipe moves, so the input is open
  a_no_stall_when_drained : assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // input only backs up once every stage holds a request
  a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r))
    else $error("input stalled with an empty stage");

  // a selected normal is never zero
  a_normal_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[2] && s3_geo_r) |-> (s3_nn_r != '0))
    else $error("geometry path taken with zero normal");

  // a zero projection carries no sign
  a_zero_proj_sign : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[2] && (s3_ap_r == '0)) |-> !s3_pneg_r)
    else $error("zero projection marked negative");

endmodule : slice_order_comparator

`default_nettype wire

// File: tb/slice_order_comparator_test.sv
// Self-checking testbench for slice_order_comparator: directed and random slice pairs.
// A scoreboard class predicts each ordering decision and checks results in order.
// Depends on soc_pkg and the slice_order_comparator RTL.
`timescale 1ns / 100ps

module slice_order_comparator_test;

  localparam int POS_W       = 21;
  localparam int COS_W       = 10;
  localparam int LATENCY     = 6;
  localparam int SETTLE      = 2 * LATENCY + 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 160;
  localparam int MAX_REPORTS = 10;

  // Sort keys of one slice, as carried by the request
  typedef struct {
    logic [soc_pkg::POS_FIELD_WIDTH-1:0]   position;
    logic [soc_pkg::ORI_FIELD_WIDTH-1:0]   orientation;
    logic [soc_pkg::FLAG_WIDTH-1:0]        flags;
    logic signed [soc_pkg::INST_WIDTH-1:0] inst_num;
    logic signed [soc_pkg::LOC_WIDTH-1:0]  location;
    logic [soc_pkg::IDX_WIDTH-1:0]         load_index;
  } slice_keys_t;

  typedef struct {
    slice_keys_t lhs;
    slice_keys_t rhs;
  } slice_pair_t;

  // Predicts left-before-right for each accepted request and checks results in order
  class order_scoreboard;
    logic [soc_pkg::TOL_WIDTH-1:0] tolerance;
    bit verdicts[$];
    int failures;
    int answered;

    function new();
      tolerance = '0;
      failures  = 0;
      answered  = 0;
    endfunction

    static function longint axis(logic [soc_pkg::POS_FIELD_WIDTH-1:0] pos, int k);
      return longint'($signed(pos[k*POS_W +: POS_W]));
    endfunction

    static function longint cosine(logic [soc_pkg::ORI_FIELD_WIDTH-1:0] ori, int k);
      return longint'($signed(ori[k*COS_W +: COS_W]));
    endfunction

    static function logic [63:0] magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // Row x column; a zero cross product counts as no normal
    function bit slice_normal(slice_keys_t s, output longint nx, output longint ny,
                              output longint nz);
      longint rx, ry, rz, cx, cy, cz;
      rx = cosine(s.orientation, 0);
      ry = cosine(s.orientation, 1);
      rz = cosine(s.orientation, 2);
      cx = cosine(s.orientation, 3);
      cy = cosine(s.orientation, 4);
      cz = cosine(s.orientation, 5);
      nx = ry * cz - rz * cy;
      ny = rz * cx - rx * cz;
      nz = rx * cy - ry * cx;
      return s.flags[soc_pkg::FLAG_ORI] && (nx != 0 || ny != 0 || nz != 0);
    endfunction

    function bit sorts_before(slice_pair_t q);
      longint d [3];
      longint nx, ny, nz, proj, li, ri, ll, rl;
      logic [63:0] tol64, norm_sq, ap;
      logic [127:0] proj_sq, limit_sq;
      bit has_normal;
      tol64 = 64'(tolerance);
      // geometry only when both slices carry a position
      if (q.lhs.flags[soc_pkg::FLAG_POS] && q.rhs.flags[soc_pkg::FLAG_POS]) begin
        for (int k = 0; k < 3; k++)
          d[k] = axis(q.lhs.position, k) - axis(q.rhs.position, k);
        has_normal = slice_normal(q.lhs, nx, ny, nz);
        if (!has_normal)
          has_normal = slice_normal(q.rhs, nx, ny, nz);
        // (d.n)^2 > tol^2 * |n|^2, exact
        if (has_normal) begin
          proj     = d[0] * nx + d[1] * ny + d[2] * nz;
          norm_sq  = nx * nx + ny * ny + nz * nz;
          ap       = magnitude(proj);
          proj_sq  = 128'(ap) * 128'(ap);
          limit_sq = 128'(tol64 * tol64) * 128'(norm_sq);
          if (proj_sq > limit_sq)
            return proj < 0;
        end
        for (int k = 0; k < 3; k++)
          if (magnitude(d[k]) > tol64)
            return d[k] < 0;
      end
      li = q.lhs.inst_num;
      ri = q.rhs.inst_num;
      if (li != ri)
        return li < ri;
      ll = q.lhs.location;
      rl = q.rhs.location;
      if (magnitude(ll - rl) > tol64)
        return ll < rl;
      return q.lhs.load_index < q.rhs.load_index;
    endfunction

    function void log_request(slice_pair_t q);
      verdicts.push_back(sorts_before(q));
    endfunction

    function void check_verdict(logic got);
      bit want;
      if (verdicts.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("result %0b arrived with no request outstanding", got);
        return;
      end
      want = verdicts.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("request %0d: left_before_right expected %0b, got %0b",
                   answered, want, got);
      end
      answered++;
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    function void close_out();
      if (verdicts.size() != 0) begin
        failures++;
        $display("%0d requests never answered", verdicts.size());
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                                  cfg_wr_en   = 1'b0;
  logic [soc_pkg::TOL_WIDTH-1:0]         cfg_wr_data = '0;

  logic                                  in_valid                = 1'b0;
  logic                                  in_stall;
  logic [soc_pkg::POS_FIELD_WIDTH-1:0]   in_left_position        = '0;
  logic [soc_pkg::ORI_FIELD_WIDTH-1:0]   in_left_orientation     = '0;
  logic [soc_pkg::FLAG_WIDTH-1:0]        in_left_flags           = '0;
  logic signed [soc_pkg::INST_WIDTH-1:0] in_left_instance        = '0;
  logic signed [soc_pkg::LOC_WIDTH-1:0]  in_left_slice_location  = '0;
  logic [soc_pkg::IDX_WIDTH-1:0]         in_left_order_index     = '0;
  logic [soc_pkg::POS_FIELD_WIDTH-1:0]   in_right_position       = '0;
  logic [soc_pkg::ORI_FIELD_WIDTH-1:0]   in_right_orientation    = '0;
  logic [soc_pkg::FLAG_WIDTH-1:0]        in_right_flags          = '0;
  logic signed [soc_pkg::INST_WIDTH-1:0] in_right_instance       = '0;
  logic signed [soc_pkg::LOC_WIDTH-1:0]  in_right_slice_location = '0;
  logic [soc_pkg::IDX_WIDTH-1:0]         in_right_order_index    = '0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic out_left_before_right;

  order_scoreboard sb = new();
  int unsigned quiet_cycles = 0;

  slice_order_comparator #(
    .POSITION_WIDTH(POS_W),
    .COSINE_WIDTH  (COS_W)
  ) u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_left_position       (in_left_position),
    .in_left_orientation    (in_left_orientation),
    .in_left_flags          (in_left_flags),
    .in_left_instance       (in_left_instance),
    .in_left_slice_location (in_left_slice_location),
    .in_left_order_index    (in_left_order_index),
    .in_right_position      (in_right_position),
    .in_right_orientation   (in_right_orientation),
    .in_right_flags         (in_right_flags),
    .in_right_instance      (in_right_instance),
    .in_right_slice_location(in_right_slice_location),
    .in_right_order_index   (in_right_order_index),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_left_before_right  (out_left_before_right)
  );

  always begin
    #1;
    clk = 1'b1;
    #1;
    clk = 1'b0;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [soc_pkg::POS_FIELD_WIDTH-1:0] pack_coords(int x, int y, int z);
    return {z[POS_W-1:0], y[POS_W-1:0], x[POS_W-1:0]};
  endfunction

  function automatic logic [soc_pkg::ORI_FIELD_WIDTH-1:0] pack_cosines(
    int rx, int ry, int rz, int cx, int cy, int cz);
    return {cz[COS_W-1:0], cy[COS_W-1:0], cx[COS_W-1:0],
            rz[COS_W-1:0], ry[COS_W-1:0], rx[COS_W-1:0]};
  endfunction

  function automatic int small_cosine();
    return int'($urandom_range(0, 600)) - 300;
  endfunction

  // Standard planes, oblique, raw bits, zero and degenerate (row parallel to column)
  function automatic logic [soc_pkg::ORI_FIELD_WIDTH-1:0] pick_orientation();
    int s, a, b, c;
    s = $urandom_range(0, 1) ? 256 : -256;
    a = small_cosine();
    b = small_cosine();
    c = small_cosine();
    case ($urandom_range(0, 7))
      0: return pack_cosines(s, 0, 0, 0, s, 0);
      1: return pack_cosines(0, s, 0, 0, 0, -256);
      2: return pack_cosines(s, 0, 0, 0, 0, -s);
      3: return pack_cosines(a, b, c, small_cosine(), small_cosine(), small_cosine());
      4: return '0;
      5: return pack_cosines(a, b, c, a, b, c);
      default: return soc_pkg::ORI_FIELD_WIDTH'({$urandom, $urandom});
    endcase
  endfunction

  // Offsets that land on, just past, or around the tolerance
  function automatic int near_delta(int tol);
    int span;
    span = 2 * tol + 8;
    case ($urandom_range(0, 5))
      0: return tol;
      1: return -tol;
      2: return tol + 1;
      3: return -(tol + 1);
      default: return int'($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  function automatic slice_keys_t random_slice();
    slice_keys_t s;
    s.position    = soc_pkg::POS_FIELD_WIDTH'({$urandom, $urandom});
    s.orientation = pick_orientation();
    s.flags       = ($urandom_range(0, 3) != 0) ? 2'b11
                                                : soc_pkg::FLAG_WIDTH'($urandom_range(0, 3));
    s.inst_num    = soc_pkg::INST_WIDTH'($urandom);
    s.location    = soc_pkg::LOC_WIDTH'($urandom);
    s.load_index  = soc_pkg::IDX_WIDTH'($urandom);
    return s;
  endfunction

  // Mostly a neighbor slice of the same series, sometimes two unrelated slices
  function automatic slice_pair_t random_pair(int tol);
    slice_pair_t q;
    int c [3];
    q.lhs = random_slice();
    q.rhs = random_slice();
    if ($urandom_range(0, 9) == 0)
      return q;
    for (int k = 0; k < 3; k++) begin
      c[k] = int'(order_scoreboard::axis(q.lhs.position, k));
      case ($urandom_range(0, 3))
        0: ;
        3: c[k] = int'(order_scoreboard::axis(q.rhs.position, k));
        default: c[k] = c[k] + near_delta(tol);
      endcase
    end
    q.rhs.position = pack_coords(c[0], c[1], c[2]);
    if ($urandom_range(0, 1))
      q.rhs.orientation = q.lhs.orientation;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: q.rhs.inst_num = q.lhs.inst_num;
      5: q.rhs.inst_num = q.lhs.inst_num + 1;
      6: q.rhs.inst_num = q.lhs.inst_num - 1;
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: q.rhs.location = q.lhs.location;
      1, 2: q.rhs.location = q.lhs.location + near_delta(tol);
      default: ;
    endcase
    if ($urandom_range(0, 4) == 0)
      q.rhs.load_index = q.lhs.load_index;
    return q;
  endfunction

  function automatic slice_pair_t swapped(slice_pair_t q);
    slice_pair_t r;
    r.lhs = q.rhs;
    r.rhs = q.lhs;
    return r;
  endfunction

  // Present one request and hold it until accepted
  task automatic send(slice_pair_t q, int unsigned gap);
    in_left_position        <= q.lhs.position;
    in_left_orientation     <= q.lhs.orientation;
    in_left_flags           <= q.lhs.flags;
    in_left_instance        <= q.lhs.inst_num;
    in_left_slice_location  <= q.lhs.location;
    in_left_order_index     <= q.lhs.load_index;
    in_right_position       <= q.rhs.position;
    in_right_orientation    <= q.rhs.orientation;
    in_right_flags          <= q.rhs.flags;
    in_right_instance       <= q.rhs.inst_num;
    in_right_slice_location <= q.rhs.location;
    in_right_order_index    <= q.rhs.load_index;
    in_valid                <= 1'b1;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_both(slice_pair_t q);
    send(q, idle_len());
    send(swapped(q), idle_len());
  endtask

  // Tolerance is only changed with the pipeline empty
  task automatic write_tolerance(logic [soc_pkg::TOL_WIDTH-1:0] value);
    in_valid <= 1'b0;
    // let the monitor log the last request before the queue is checked
    @(posedge clk);
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    sb.tolerance = value;
  endtask

  task automatic run_directed();
    slice_pair_t z, q;
    z.lhs = '{default: '0};
    z.rhs = '{default: '0};
    // equal keys, nothing present
    send(z, idle_len());
    // identical slices with full geometry
    q = z;
    q.lhs.flags       = 2'b11;
    q.lhs.orientation = pack_cosines(256, 0, 0, 0, 256, 0);
    q.rhs             = q.lhs;
    send(q, idle_len());
    // load order extremes
    q = z;
    q.rhs.load_index = '1;
    send_both(q);
    // instance extremes
    q = z;
    q.lhs.inst_num = -24'sd8388608;
    q.rhs.inst_num = 24'sd8388607;
    send_both(q);
    // slice location extremes
    q = z;
    q.lhs.location = -21'sd1048576;
    q.rhs.location = 21'sd1048575;
    send_both(q);
    // positions only, x at the extremes
    q = z;
    q.lhs.flags    = 2'b01;
    q.rhs.flags    = 2'b01;
    q.lhs.position = pack_coords(-1048576, 0, 0);
    q.rhs.position = pack_coords(1048575, 0, 0);
    send_both(q);
    // axial normal from the left; projection disagrees with x
    q = z;
    q.lhs.flags       = 2'b11;
    q.rhs.flags       = 2'b11;
    q.lhs.orientation = pack_cosines(256, 0, 0, 0, 256, 0);
    q.lhs.position    = pack_coords(0, 0, 1);
    q.rhs.position    = pack_coords(5, 0, 0);
    send_both(q);
    // left orientation present but zero: right normal used
    q.rhs.orientation = q.lhs.orientation;
    q.lhs.orientation = '0;
    send(q, idle_len());
    // left orientation absent
    q.lhs.flags = 2'b01;
    send(q, idle_len());
    // both normals degenerate: per-axis compare on y
    q = z;
    q.lhs.flags       = 2'b11;
    q.rhs.flags       = 2'b11;
    q.lhs.orientation = pack_cosines(100, 50, -20, 100, 50, -20);
    q.rhs.orientation = q.lhs.orientation;
    q.lhs.position    = pack_coords(0, -3, 0);
    q.rhs.position    = pack_coords(0, 4, 0);
    send_both(q);
    // only one position present: geometry skipped
    q = z;
    q.lhs.flags    = 2'b01;
    q.lhs.position = pack_coords(-900000, 900000, -900000);
    q.rhs.position = pack_coords(900000, -900000, 900000);
    q.lhs.inst_num = 24'sd7;
    q.rhs.inst_num = 24'sd5;
    send_both(q);
    // all ones against all zeros but for both flags set on the right
    q = z;
    q.lhs = '{default: '1};
    q.rhs.flags = 2'b11;
    send_both(q);
    // extreme cosines and coordinates
    q = z;
    q.lhs.flags       = 2'b11;
    q.rhs.flags       = 2'b11;
    q.lhs.orientation = pack_cosines(511, -512, 0, 0, 511, -512);
    q.lhs.position    = pack_coords(1048575, -1048576, 1048575);
    q.rhs.position    = pack_coords(-1048576, 1048575, -1048576);
    send_both(q);
  endtask

  task automatic run_random(int count);
    bit burst;
    burst = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0)
        burst = ($urandom_range(0, 2) == 0);
      send(random_pair(int'(sb.tolerance)), burst ? 0 : idle_len());
    end
  endtask

  // Result-side stall: free runs of varied length, mostly short stalls
  initial begin : result_backpressure
    int unsigned run;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      out_stall <= 1'b1;
      repeat (idle_len() + 1) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // Accepted requests feed the predictor; accepted results are checked
  always @(posedge clk) begin : handshake_monitor
    slice_pair_t seen;
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_verdict(out_left_before_right);
      if (in_valid && !in_stall) begin
        seen.lhs.position    = in_left_position;
        seen.lhs.orientation = in_left_orientation;
        seen.lhs.flags       = in_left_flags;
        seen.lhs.inst_num    = in_left_instance;
        seen.lhs.location    = in_left_slice_location;
        seen.lhs.load_index  = in_left_order_index;
        seen.rhs.position    = in_right_position;
        seen.rhs.orientation = in_right_orientation;
        seen.rhs.flags       = in_right_flags;
        seen.rhs.inst_num    = in_right_instance;
        seen.rhs.location    = in_right_slice_location;
        seen.rhs.load_index  = in_right_order_index;
        sb.log_request(seen);
      end
    end
  end

  // Watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[slice_order_comparator] ERROR");
    $finish;
  end

  initial begin : main_sequence
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // tolerance at its reset value of zero
    run_directed();
    run_random(PHASE_ITEMS);
    write_tolerance('1);
    run_random(PHASE_ITEMS);
    write_tolerance('0);
    run_random(PHASE_ITEMS);
    write_tolerance(soc_pkg::TOL_WIDTH'(1));
    run_random(PHASE_ITEMS);
    write_tolerance(soc_pkg::TOL_WIDTH'($urandom_range(2, 4096)));
    run_random(PHASE_ITEMS);
    write_tolerance(soc_pkg::TOL_WIDTH'($urandom));
    run_random(PHASE_ITEMS);
    // drain, then leave room for stray results
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    sb.close_out();
    if (sb.failures == 0)
      $display("[slice_order_comparator] OK");
    else
      $display("[slice_order_comparator] ERROR");
    $finish;
  end

endmodule
